@@ rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS        = 80;
  localparam int ROW_COUNT      = 25;
  localparam int TAB_STOP       = 8;
  localparam int SCREEN_SIZE    = COLUMNS * ROW_COUNT;
  localparam int LAST_ROW_START = SCREEN_SIZE - COLUMNS;

  // The cursor can pass the screen size by one line feed or one tab at most.
  localparam int MAX_CURSOR = SCREEN_SIZE + ((COLUMNS > TAB_STOP) ? COLUMNS : TAB_STOP);

  // Widths.
  localparam int ADDR_W       = $clog2(SCREEN_SIZE);
  localparam int CUR_W        = $clog2(MAX_CURSOR + 1);
  localparam int COL_W        = $clog2(COLUMNS);
  localparam int TPH_W        = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int CELL_W       = 16;
  localparam int CHAR_W       = 8;
  localparam int INDEX_W      = 11;
  localparam int CURSOR_OUT_W = 11;
  localparam int S_DATA_W     = 32;
  localparam int S_USER_W     = 1;
  localparam int M_DATA_W     = 32;

  // Reciprocals for the remainder by a constant: q = (x * R) >> CUR_W is
  // the true quotient or one less, for every cursor value.
  localparam int RECIP_W   = CUR_W + 1;
  localparam int PROD_W    = CUR_W + RECIP_W;
  localparam int RECIP_COL = (2 ** CUR_W) / COLUMNS;
  localparam int RECIP_TAB = (2 ** CUR_W) / TAB_STOP;

  // Item kinds.
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0d;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_MUL1  = 9'b000001000,
    ST_MUL2  = 9'b000010000,
    ST_FIX   = 9'b000100000,
    ST_MOVE  = 9'b001000000,
    ST_WIPE  = 9'b010000000,
    ST_WRITE = 9'b100000000
  } state_t;

  // Logical cell index to physical RAM address, with the row ring offset.
  function automatic logic [ADDR_W-1:0] map_addr(input logic [ADDR_W-1:0] idx,
                                                input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, idx} + {1'b0, off};
    if (sum >= (ADDR_W + 1)'(SCREEN_SIZE)) begin
      sum = sum - (ADDR_W + 1)'(SCREEN_SIZE);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/text_console_writer.sv @@
`default_nettype none

// Channel  Dir  Word layout (low bit first)                          Kind
// s_*      in   tdata: cell_value[15:0], read_index[26:16], zeros      item
//               tuser: action[0]
// m_*      out  tdata: read_cell[15:0], cursor[26:16], scrolled[27]   result
//
// Reads finish in ST_READ, visible characters and backspace in ST_MOVE; a zero
// character finishes in ST_IDLE. Line feed, carriage return and tab pass ST_MUL1,
// ST_MUL2 and ST_FIX first: the cursor remainders by the row length and tab stop
// go through a two-step reciprocal multiply. A scroll wipes the recycled row in
// ST_WIPE, then a visible character is written in ST_WRITE. After reset the screen
// RAM is cleared, one cell a cycle. A word is taken only while the output register
// is empty or being read, so a stalled receiver stalls the input.

module text_console_writer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // cell_value[15:0], read_index[26:16], zero fill
  input  logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
  // action[0]
  input  logic [tcw_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // read_cell[15:0], cursor[26:16], scrolled[27], zero fill
  output logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);

  import tcw_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [CUR_W-1:0]    cursor;
  logic [CUR_W-1:0]    cursor_next;
  logic [ADDR_W-1:0]   offset;
  logic [ADDR_W-1:0]   offset_next;
  logic [ADDR_W-1:0]   cnt;
  logic [ADDR_W-1:0]   cnt_next;
  logic [CELL_W-1:0]   value;
  logic                in_range;
  logic                scrolled;
  logic [CUR_W-1:0]    q_col;
  logic [CUR_W-1:0]    q_tab;
  logic [CUR_W-1:0]    p_col;
  logic [CUR_W-1:0]    p_tab;
  logic [COL_W-1:0]    col;
  logic [TPH_W-1:0]    tph;
  logic [M_DATA_W-1:0] out_data;

  logic                in_action;
  logic [CELL_W-1:0]   in_value;
  logic [INDEX_W-1:0]  in_index;
  logic [CHAR_W-1:0]   in_char;
  logic                in_ok;
  logic                accept;
  logic                out_free;
  logic                finish;
  logic [CELL_W-1:0]   res_cell;
  logic                res_scrolled;
  logic [CHAR_W-1:0]   cur_char;
  logic                visible;
  logic [CUR_W-1:0]    moved;
  logic                need_scroll;
  logic [PROD_W-1:0]   prod_col;
  logic [PROD_W-1:0]   prod_tab;
  logic [CUR_W-1:0]    rem_col;
  logic [CUR_W-1:0]    rem_tab;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  // Input word fields.
  assign in_action = s_tuser[0];
  assign in_value  = s_tdata[CELL_W-1:0];
  assign in_index  = s_tdata[CELL_W +: INDEX_W];
  assign in_char   = in_value[CHAR_W-1:0];
  assign in_ok     = (32'(in_index) < 32'(SCREEN_SIZE));

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = out_data;

  // Remainders of the cursor by the row length and by the tab stop.
  assign prod_col = PROD_W'(cursor) * PROD_W'(RECIP_COL);
  assign prod_tab = PROD_W'(cursor) * PROD_W'(RECIP_TAB);
  assign rem_col  = cursor - p_col;
  assign rem_tab  = cursor - p_tab;

  // Cursor movement for the held character.
  assign cur_char = value[CHAR_W-1:0];
  always_comb begin
    visible = 1'b0;
    unique case (cur_char)
      CH_BS:   moved = (cursor != '0) ? cursor - CUR_W'(1) : cursor;
      CH_LF:   moved = cursor + CUR_W'(COLUMNS) - CUR_W'(col);
      CH_CR:   moved = cursor - CUR_W'(col);
      CH_TAB:  moved = cursor + CUR_W'(TAB_STOP) - CUR_W'(tph);
      default: begin
        moved   = cursor;
        visible = 1'b1;
      end
    endcase
  end
  assign need_scroll = (moved >= CUR_W'(SCREEN_SIZE));

  // Sequencer and RAM port control.
  always_comb begin
    state_next   = state;
    cursor_next  = cursor;
    offset_next  = offset;
    cnt_next     = cnt;
    finish       = 1'b0;
    res_cell     = '0;
    res_scrolled = scrolled;
    ram_we       = 1'b0;
    ram_waddr    = map_addr(ADDR_W'(cursor), offset);
    ram_wdata    = value;
    ram_re       = 1'b0;
    ram_raddr    = map_addr(ADDR_W'(in_index), offset);

    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
        cnt_next  = cnt + ADDR_W'(1);
        if (cnt == ADDR_W'(SCREEN_SIZE - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // A zero character finishes here and never scrolls.
        res_scrolled = 1'b0;
        if (accept) begin
          unique case (in_action)
            ACT_READ: begin
              ram_re     = in_ok;
              state_next = ST_READ;
            end
            ACT_PUT: begin
              unique case (in_char) inside
                CH_NUL:               finish = 1'b1;
                CH_LF, CH_CR, CH_TAB: state_next = ST_MUL1;
                default:              state_next = ST_MOVE;
              endcase
            end
          endcase
        end
      end
      ST_READ: begin
        res_cell = in_range ? ram_rdata : '0;
        finish   = 1'b1;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_FIX;
      ST_FIX:  state_next = ST_MOVE;
      ST_MOVE: begin
        if (need_scroll) begin
          // Recycle the top row as the new last row.
          cursor_next = CUR_W'(LAST_ROW_START);
          offset_next = map_addr(ADDR_W'(COLUMNS), offset);
          cnt_next    = '0;
          state_next  = ST_WIPE;
        end else if (visible) begin
          ram_we      = 1'b1;
          cursor_next = cursor + CUR_W'(1);
          finish      = 1'b1;
        end else begin
          cursor_next = moved;
          finish      = 1'b1;
        end
      end
      ST_WIPE: begin
        ram_we    = 1'b1;
        ram_waddr = map_addr(ADDR_W'(LAST_ROW_START) + cnt, offset);
        ram_wdata = '0;
        cnt_next  = cnt + ADDR_W'(1);
        if (cnt == ADDR_W'(COLUMNS - 1)) begin
          cnt_next = '0;
          if (visible) begin
            state_next = ST_WRITE;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_WRITE: begin
        ram_we      = 1'b1;
        cursor_next = cursor + CUR_W'(1);
        finish      = 1'b1;
      end
      default: state_next = ST_IDLE;
    endcase

    // An item is only taken with the output register free, so a result always leaves.
    if (finish) begin
      state_next = ST_IDLE;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cursor   <= '0;
      offset   <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      offset <= offset_next;
      cnt    <= cnt_next;
      if (finish && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Held item, remainder pipeline and result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      value    <= in_value;
      in_range <= in_ok;
      scrolled <= 1'b0;
    end else if (state == ST_MOVE && need_scroll) begin
      scrolled <= 1'b1;
    end
    if (state == ST_MUL1) begin
      q_col <= prod_col[CUR_W +: CUR_W];
      q_tab <= prod_tab[CUR_W +: CUR_W];
    end
    if (state == ST_MUL2) begin
      p_col <= q_col * CUR_W'(COLUMNS);
      p_tab <= q_tab * CUR_W'(TAB_STOP);
    end
    if (state == ST_FIX) begin
      col <= (rem_col >= CUR_W'(COLUMNS)) ? COL_W'(rem_col - CUR_W'(COLUMNS)) : COL_W'(rem_col);
      tph <= (rem_tab >= CUR_W'(TAB_STOP)) ? TPH_W'(rem_tab - CUR_W'(TAB_STOP))
                                           : TPH_W'(rem_tab);
    end
    if (finish && out_free) begin
      out_data <= M_DATA_W'({res_scrolled, CURSOR_OUT_W'(cursor_next), res_cell});
    end
  end

  // Screen memory, rows kept as a ring behind the offset.
  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(SCREEN_SIZE)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The cursor never runs past one movement beyond the screen.
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= CUR_W'(MAX_CURSOR))
    else $error("cursor out of range");

  // The ring offset always names a row start inside the screen.
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    32'(offset) < 32'(LAST_ROW_START + 1))
    else $error("ring offset out of range");

  // A read is never issued while the memory is written.
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !ram_we)
    else $error("read and write in the same cycle");

  // A scroll starts a row wipe with the cursor on the last row.
  a_scroll_wipe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE && need_scroll) |=>
      (state == ST_WIPE && cnt == '0 && cursor == CUR_W'(LAST_ROW_START) && scrolled))
    else $error("scroll did not start a row wipe");

endmodule

`default_nettype wire

@@ rtl/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_text_console_writer.sv @@
`default_nettype none

module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // One result word, unpacked from m_tdata.
  typedef struct packed {
    logic [CELL_W-1:0]       read_cell;
    logic [CURSOR_OUT_W-1:0] cursor;
    logic                    scrolled;
  } console_result_t;

  // One directed row; a row with want_typed set carries its result by hand.
  typedef struct packed {
    logic                act;
    logic [CELL_W-1:0]   value;
    logic [INDEX_W-1:0]  index;
    int                  reps;
    bit                  want_typed;
    console_result_t     want;
  } console_step_t;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 120;
  localparam int PHASE_WORDS   = 200;
  localparam int PLAN_ROWS     = 27;

  // Directed plan: corners first, then runs that fill the last row and scroll.
  localparam console_step_t PLAN [0:PLAN_ROWS-1] = '{
    '{ACT_READ, 16'h0000, 11'd0,    1,  1'b1, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_READ, 16'hffff, 11'h7ff,  1,  1'b1, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'hff08, 11'h7ff,  1,  1'b1, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'hff00, 11'd0,    1,  1'b1, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'h0741, 11'd0,    1,  1'b1, '{16'h0000, 11'd1,    1'b0}},
    '{ACT_READ, 16'h0000, 11'd0,    1,  1'b1, '{16'h0741, 11'd1,    1'b0}},
    '{ACT_PUT,  16'h0008, 11'd0,    1,  1'b1, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'h0009, 11'd0,    1,  1'b1, '{16'h0000, 11'd8,    1'b0}},
    '{ACT_PUT,  16'h000d, 11'd0,    1,  1'b1, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'h000a, 11'd0,    1,  1'b1, '{16'h0000, 11'd80,   1'b0}},
    '{ACT_PUT,  16'hffff, 11'd0,    1,  1'b1, '{16'h0000, 11'd81,   1'b0}},
    '{ACT_READ, 16'h0000, 11'd80,   1,  1'b1, '{16'hffff, 11'd81,   1'b0}},
    '{ACT_READ, 16'h0000, 11'd1999, 1,  1'b1, '{16'h0000, 11'd81,   1'b0}},
    '{ACT_READ, 16'h0000, 11'd2000, 1,  1'b1, '{16'h0000, 11'd81,   1'b0}},
    '{ACT_PUT,  16'h800a, 11'd0,    23, 1'b0, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'h0f58, 11'd0,    80, 1'b0, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'h0008, 11'd0,    1,  1'b1, '{16'h0000, 11'd1999, 1'b0}},
    '{ACT_PUT,  16'h0009, 11'd0,    1,  1'b1, '{16'h0000, 11'd1920, 1'b1}},
    '{ACT_PUT,  16'h7f7e, 11'd0,    80, 1'b0, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'h000d, 11'd0,    1,  1'b1, '{16'h0000, 11'd1920, 1'b1}},
    '{ACT_PUT,  16'h000a, 11'd0,    1,  1'b1, '{16'h0000, 11'd1920, 1'b1}},
    '{ACT_PUT,  16'h4e01, 11'd0,    80, 1'b0, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'h5500, 11'd0,    1,  1'b1, '{16'h0000, 11'd2000, 1'b0}},
    '{ACT_PUT,  16'h0131, 11'd0,    1,  1'b1, '{16'h0000, 11'd1921, 1'b1}},
    '{ACT_READ, 16'h0000, 11'd1920, 1,  1'b1, '{16'h0131, 11'd1921, 1'b0}},
    '{ACT_READ, 16'h0000, 11'd1840, 1,  1'b0, '{16'h0000, 11'd0,    1'b0}},
    '{ACT_PUT,  16'h80ff, 11'd0,    1,  1'b0, '{16'h0000, 11'd0,    1'b0}}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // Shadow copy of the screen and cursor.
  logic [CELL_W-1:0] screen_shadow [SCREEN_SIZE];
  int                cursor_shadow;

  console_result_t pending_results [$];
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_seq       = 0;
  int  hold_seen      = 0;
  int  hold_left      = 0;
  int  cycle_count    = 0;
  int  failures       = 0;
  int  words_sent     = 0;
  int  results_seen   = 0;
  int  scrolls_seen   = 0;
  int  reads_seen     = 0;

  text_console_writer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one word to the shadow screen and return the result it causes.
  function automatic console_result_t console_apply(input logic act,
                                                    input logic [CELL_W-1:0] value,
                                                    input logic [INDEX_W-1:0] index);
    console_result_t res;
    logic [CHAR_W-1:0] ch;
    int  pos;
    bit  visible;
    bit  acts;
    res = '0;
    if (act == ACT_READ) begin
      if (int'(index) < SCREEN_SIZE) res.read_cell = screen_shadow[index];
    end else begin
      ch      = value[CHAR_W-1:0];
      pos     = cursor_shadow;
      visible = 1'b0;
      acts    = 1'b1;
      case (ch)
        CH_NUL: acts = 1'b0;
        CH_BS:  if (pos != 0) pos = pos - 1;
        CH_LF:  pos = pos + COLUMNS - (pos % COLUMNS);
        CH_CR:  pos = pos - (pos % COLUMNS);
        CH_TAB: pos = pos + TAB_STOP - (pos % TAB_STOP);
        default: visible = 1'b1;
      endcase
      // A cursor at or past the end scrolls the screen up by one row.
      if (acts && pos >= SCREEN_SIZE) begin
        for (int i = 0; i < LAST_ROW_START; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
        for (int i = LAST_ROW_START; i < SCREEN_SIZE; i++) screen_shadow[i] = '0;
        pos = LAST_ROW_START;
        res.scrolled = 1'b1;
      end
      if (acts && visible && pos < SCREEN_SIZE) begin
        screen_shadow[pos] = value;
        pos = pos + 1;
      end
      cursor_shadow = pos;
    end
    res.cursor = CURSOR_OUT_W'(cursor_shadow);
    return res;
  endfunction

  // Offer one word after a random gap; record its result once accepted.
  task automatic send_word(input logic act, input logic [CELL_W-1:0] value,
                           input logic [INDEX_W-1:0] index, input bit want_typed,
                           input console_result_t want);
    console_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, index, value};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    predicted = console_apply(act, value, index);
    pending_results.push_back(want_typed ? want : predicted);
    words_sent++;
  endtask

  // Wait until every expected result has come back.
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when the sender asks for one.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[15:0], m_tdata[26:16], m_tdata[27]};
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", m_tdata);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.read_cell !== want.read_cell) begin
          $error("read_cell: expected %h, got %h", want.read_cell, got.read_cell);
          failures++;
        end
        if (got.cursor !== want.cursor) begin
          $error("cursor: expected %0d, got %0d", want.cursor, got.cursor);
          failures++;
        end
        if (got.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
          failures++;
        end
        if (want.scrolled) scrolls_seen++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic              act;
    logic [CELL_W-1:0] value;
    logic [INDEX_W-1:0] index;
    int                pick;
    for (int i = 0; i < SCREEN_SIZE; i++) screen_shadow[i] = '0;
    cursor_shadow = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows, no idling on either side.
    foreach (PLAN[r]) begin
      for (int k = 0; k < PLAN[r].reps; k++) begin
        send_word(PLAN[r].act, PLAN[r].value, PLAN[r].index, PLAN[r].want_typed,
                  PLAN[r].want);
      end
    end

    // Random words over four idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Back up the output side once so the block fills and stalls its input.
        if (phase == 0 && n == 20) hold_seq <= hold_seq + 1;
        value = CELL_W'($urandom);
        index = INDEX_W'($urandom);
        act   = ACT_PUT;
        pick  = $urandom_range(99);
        if (pick < 25) begin
          act = ACT_READ;
          if ($urandom_range(9) != 0) index = INDEX_W'($urandom_range(SCREEN_SIZE - 1));
        end else if (pick < 31) begin
          value[CHAR_W-1:0] = CH_NUL;
        end else if (pick < 37) begin
          value[CHAR_W-1:0] = CH_BS;
        end else if (pick < 49) begin
          value[CHAR_W-1:0] = CH_LF;
        end else if (pick < 53) begin
          value[CHAR_W-1:0] = CH_CR;
        end else if (pick < 59) begin
          value[CHAR_W-1:0] = CH_TAB;
        end
        send_word(act, value, index, 1'b0, '0);
      end
      // Let the sender pause until every result of the phase is back.
      s_tvalid <= 1'b0;
      drain_results();
    end

    s_tvalid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words (%0d results, %0d scrolls), directed corners and",
             words_sent, results_seen, scrolls_seen);
    $display("random puts and reads under four idle and stall mixes plus a long hold-off.");
    if (failures == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer.sv
tb/tb_text_console_writer.sv
